[src/dsp_event_combiner_and_int_mux_top_assert.svh]
// Assertion macros for the event combiner and interrupt mux top level.
`ifndef DSP_EVENT_COMBINER_AND_INT_MUX_TOP_ASSERT_SVH
`define DSP_EVENT_COMBINER_AND_INT_MUX_TOP_ASSERT_SVH

// Checked only outside reset.
`define DSP_EC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define DSP_EC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/dsp_ec_pkg.sv]
// Shared types and constants of the event combiner and interrupt mux.
package dsp_ec_pkg;

  localparam int ACTION_W   = 4;
  localparam int EVENT_W    = 7;
  localparam int LINE_W     = 4;
  localparam int WORD_W     = 32;
  localparam int LINES_W    = 4;
  localparam int MAP_LINES  = 12;
  localparam int MAP_IDX_W  = 4;
  localparam int FIRST_LINE = 4;
  localparam int LOW_EVENTS = 4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_RAISE     = 4'd0,
    ACT_READ_FLAG = 4'd1,
    ACT_SET       = 4'd2,
    ACT_CLEAR     = 4'd3,
    ACT_MASK      = 4'd4,
    ACT_UNMASK    = 4'd5,
    ACT_MAP       = 4'd6,
    ACT_READ_MAP  = 4'd7,
    ACT_COMBINED  = 4'd8
  } action_t;

  // Write controls from the decoder to the flag/mask store.
  typedef struct packed {
    logic flag_we;
    logic flag_val;
    logic mask_we;
    logic mask_val;
  } flag_cmd_t;

endpackage

[src/dsp_ec_prienc.sv]
// Lowest-set-bit priority encoder for one event group.
module dsp_ec_prienc import dsp_ec_pkg::*; #(
  parameter int W = 32
) (
  input  logic [W-1:0]         word,
  output logic [$clog2(W)-1:0] idx,
  output logic                 hit
);

  always_comb begin
    idx = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (word[i]) begin
        idx = ($clog2(W))'(i);
      end
    end
  end

  assign hit = |word;

endmodule

[src/dsp_ec_map.sv]
// Interrupt mux table: DSP lines 4..15 to event numbers.
module dsp_ec_map import dsp_ec_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 we,
  input  logic [MAP_IDX_W-1:0] idx,
  input  logic [EVENT_W-1:0]   wdata,
  output logic [EVENT_W-1:0]   rdata
);

  logic [EVENT_W-1:0] map_q [MAP_LINES];

  always_ff @(posedge clk) begin
    if (rst) begin
      map_q <= '{default: '0};
    end else if (we) begin
      map_q[idx] <= wdata;
    end
  end

  assign rdata = map_q[idx];

endmodule

[src/dsp_ec_flags.sv]
// Pending flag and mask store, grouped, with group status after update.
module dsp_ec_flags import dsp_ec_pkg::*; #(
  parameter int NUM_GROUPS = 4,
  parameter int GROUP_BITS = 32,
  parameter int GW         = 2,
  parameter int OW         = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  flag_cmd_t             cmd,
  input  logic [GW-1:0]         grp,
  input  logic [OW-1:0]         off,
  output logic                  flag_bit,
  output logic [GROUP_BITS-1:0] live_word,
  output logic [LINES_W-1:0]    lines_next
);

  logic [GROUP_BITS-1:0] pend      [NUM_GROUPS];
  logic [GROUP_BITS-1:0] mask      [NUM_GROUPS];
  logic [GROUP_BITS-1:0] pend_next [NUM_GROUPS];
  logic [GROUP_BITS-1:0] mask_next [NUM_GROUPS];

  always_comb begin
    pend_next = pend;
    mask_next = mask;
    if (cmd.flag_we) begin
      pend_next[grp][off] = cmd.flag_val;
    end
    if (cmd.mask_we) begin
      mask_next[grp][off] = cmd.mask_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '{default: '0};
      mask <= '{default: '0};
    end else begin
      pend <= pend_next;
      mask <= mask_next;
    end
  end

  assign flag_bit  = pend[grp][off];
  assign live_word = pend[grp] & ~mask[grp];

  // combined lines only cover the first four groups
  for (genvar g = 0; g < LINES_W; g++) begin : g_line
    if (g < NUM_GROUPS) begin : g_have
      assign lines_next[g] = |(pend_next[g] & ~mask_next[g]);
    end else begin : g_none
      assign lines_next[g] = 1'b0;
    end
  end

endmodule

[src/dsp_event_combiner_and_int_mux_top.sv]
// Top level of the event combiner and interrupt mux.
//
// Use:
//   A command word (action, event_number, dsp_interrupt) is taken at a rising
//   edge where start is high and busy is low. busy is low in normal running,
//   so a new word may come every cycle; it is high while rst is held and in
//   the first cycle after reset is released.
//   The word is held in an input register, decoded in the next cycle against
//   the flag, mask and mux state, and the state update and the result land in
//   the same edge. strobe marks the result for exactly one cycle; it comes from
//   the result register that follows the input register. Throughput: 1 word/cycle.
//   Each word sees the state left by the word before it.
//   The receiver cannot stall: a result is gone after its strobe cycle.
//   Result fields that do not belong to the action read zero; combined_lines
//   is the per-group status after the access and comes with every result.
//   Reset (rst, synchronous) clears all flags, masks and mux entries and
//   drops any word in flight.
//   Rate is set by the combinational pass through the group select, one
//   GROUP_BITS-wide priority encoder and the offset add.
`include "dsp_event_combiner_and_int_mux_top_assert.svh"

module dsp_event_combiner_and_int_mux_top import dsp_ec_pkg::*; #(
  parameter int NUM_EVENTS = 128,
  parameter int GROUP_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [ACTION_W-1:0] action,
  input  logic [EVENT_W-1:0]  event_number,
  input  logic [LINE_W-1:0]   dsp_interrupt,
  output logic                strobe,
  output logic                flag_before,
  output logic [EVENT_W-1:0]  previous_event,
  output logic [WORD_W-1:0]   combined_word,
  output logic [EVENT_W-1:0]  first_pending,
  output logic                found,
  output logic [LINES_W-1:0]  combined_lines,
  output logic                error
);

  localparam int NUM_GROUPS = (NUM_EVENTS + GROUP_BITS - 1) / GROUP_BITS;
  localparam int GW         = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int OW         = $clog2(GROUP_BITS);
  localparam int FP_W       = EVENT_W + OW + 1;

  // input register
  logic                vld_q;
  logic [ACTION_W-1:0] act_q;
  logic [EVENT_W-1:0]  ev_q;
  logic [LINE_W-1:0]   line_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b1;
      vld_q <= 1'b0;
    end else begin
      busy  <= 1'b0;
      vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      act_q  <= action;
      ev_q   <= event_number;
      line_q <= dsp_interrupt;
    end
  end

  // event number -> group and bit offset (constant compare chain)
  logic [GW-1:0]      ev_grp;
  logic [EVENT_W-1:0] ev_base;
  logic [OW-1:0]      ev_off;

  always_comb begin
    ev_grp  = '0;
    ev_base = '0;
    for (int g = 1; g < NUM_GROUPS; g++) begin
      if (32'(ev_q) >= g * GROUP_BITS) begin
        ev_grp  = GW'(g);
        ev_base = EVENT_W'(g * GROUP_BITS);
      end
    end
  end

  assign ev_off = OW'(ev_q - ev_base);

  logic ev_ok;
  logic grp_ok;
  logic line_ok;
  logic is_comb;
  assign ev_ok   = 32'(ev_q) < NUM_EVENTS;
  assign grp_ok  = 32'(ev_q) < NUM_GROUPS;
  assign line_ok = 32'(line_q) >= FIRST_LINE;
  assign is_comb = act_q == ACT_COMBINED;

  logic [GW-1:0] sel_grp;
  assign sel_grp = is_comb ? ev_q[GW-1:0] : ev_grp;

  // decode
  flag_cmd_t cmd;
  logic      map_we;
  logic      bad;

  always_comb begin
    cmd    = '0;
    map_we = 1'b0;
    bad    = 1'b0;
    unique case (act_q)
      ACT_RAISE, ACT_SET: begin
        bad          = !ev_ok;
        cmd.flag_we  = vld_q && ev_ok;
        cmd.flag_val = 1'b1;
      end
      ACT_CLEAR: begin
        bad          = !ev_ok;
        cmd.flag_we  = vld_q && ev_ok;
        cmd.flag_val = 1'b0;
      end
      ACT_READ_FLAG: begin
        bad = !ev_ok;
      end
      ACT_MASK, ACT_UNMASK: begin
        bad          = !ev_ok || (32'(ev_q) < LOW_EVENTS);
        cmd.mask_we  = vld_q && !bad;
        cmd.mask_val = act_q == ACT_MASK;
      end
      ACT_MAP: begin
        bad    = !line_ok;
        map_we = vld_q && line_ok;
      end
      ACT_READ_MAP: begin
        bad = !line_ok;
      end
      ACT_COMBINED: begin
        bad = !grp_ok;
      end
      default: begin
        bad = 1'b1;
      end
    endcase
  end

  // datapath units
  logic                  flag_bit;
  logic [GROUP_BITS-1:0] live_word;
  logic [LINES_W-1:0]    lines_next;
  logic [EVENT_W-1:0]    map_rdata;
  logic [OW-1:0]         enc_idx;
  logic                  enc_hit;

  dsp_ec_flags #(
    .NUM_GROUPS (NUM_GROUPS),
    .GROUP_BITS (GROUP_BITS),
    .GW         (GW),
    .OW         (OW)
  ) u_flags (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .grp        (sel_grp),
    .off        (ev_off),
    .flag_bit   (flag_bit),
    .live_word  (live_word),
    .lines_next (lines_next)
  );

  dsp_ec_map u_map (
    .clk   (clk),
    .rst   (rst),
    .we    (map_we),
    .idx   (MAP_IDX_W'(line_q - LINE_W'(FIRST_LINE))),
    .wdata (ev_q),
    .rdata (map_rdata)
  );

  dsp_ec_prienc #(
    .W (GROUP_BITS)
  ) u_enc (
    .word (live_word),
    .idx  (enc_idx),
    .hit  (enc_hit)
  );

  logic [FP_W-1:0] fp_sum;
  assign fp_sum = FP_W'(ev_q) * FP_W'(GROUP_BITS) + FP_W'(enc_idx);

  // result fields
  logic               flag_before_next;
  logic [EVENT_W-1:0] previous_event_next;
  logic [WORD_W-1:0]  combined_word_next;
  logic [EVENT_W-1:0] first_pending_next;
  logic               found_next;

  always_comb begin
    flag_before_next    = 1'b0;
    previous_event_next = '0;
    combined_word_next  = '0;
    first_pending_next  = '0;
    found_next          = 1'b0;
    if (!bad) begin
      priority if (act_q == ACT_RAISE || act_q == ACT_READ_FLAG ||
                   act_q == ACT_SET || act_q == ACT_CLEAR) begin
        flag_before_next = flag_bit;
      end else if (act_q == ACT_MAP || act_q == ACT_READ_MAP) begin
        previous_event_next = map_rdata;
      end else if (is_comb) begin
        combined_word_next = WORD_W'(live_word);
        found_next         = enc_hit;
        first_pending_next = enc_hit ? fp_sum[EVENT_W-1:0] : '0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= vld_q;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_q) begin
      flag_before    <= flag_before_next;
      previous_event <= previous_event_next;
      combined_word  <= combined_word_next;
      first_pending  <= first_pending_next;
      found          <= found_next;
      combined_lines <= lines_next;
      error          <= bad;
    end
  end

  // checks
  `DSP_EC_ASSERT(a_latency, (start && !busy) |-> ##2 strobe, "word accepted without result")
  `DSP_EC_ASSERT(a_err_quiet, (strobe && error) |-> (!flag_before && previous_event == '0 && combined_word == '0 && !found), "rejected access returned data")
  `DSP_EC_ASSERT(a_found, strobe |-> (found == (combined_word != '0)), "found disagrees with combined word")
  `DSP_EC_ASSERT_ALWAYS(a_reset, rst |=> (busy && !strobe), "reset left block active")

endmodule

[tb/tb.sv]
// Testbench for the event combiner and interrupt mux: directed and random accesses.
`timescale 1ns / 1ps

module tb;
  import dsp_ec_pkg::*;

  // Event space as built: 128 events in 4 groups of 32.
  localparam int GROUPS = 4;
  localparam int LAST_LINE = FIRST_LINE + MAP_LINES - 1;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_FIRST = ACTION_W'(ACT_COMBINED + 1);
  localparam logic [ACTION_W-1:0] ACT_UNUSED_LAST = '1;
  localparam int DRAIN_CYCLES = 8;       // covers the input and result registers, with margin on top

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [ACTION_W-1:0] action = '0;
  logic [EVENT_W-1:0] event_number = '0;
  logic [LINE_W-1:0] dsp_interrupt = '0;
  logic strobe;
  logic flag_before;
  logic [EVENT_W-1:0] previous_event;
  logic [WORD_W-1:0] combined_word;
  logic [EVENT_W-1:0] first_pending;
  logic found;
  logic [LINES_W-1:0] combined_lines;
  logic error;

  // One reply word of the controller.
  typedef struct packed {
    logic flag_before;
    logic [EVENT_W-1:0] previous_event;
    logic [WORD_W-1:0] combined_word;
    logic [EVENT_W-1:0] first_pending;
    logic found;
    logic [LINES_W-1:0] combined_lines;
    logic error;
  } access_reply_t;

  // Shadow copy of the controller state.
  logic [WORD_W-1:0] flag_bank[GROUPS];
  logic [WORD_W-1:0] mask_bank[GROUPS];
  logic [EVENT_W-1:0] irq_map[MAP_LINES];

  access_reply_t access_replies[$];
  access_reply_t reply_head;
  int mismatches = 0;
  int replies_seen = 0;
  bit idle_on = 1'b1;

  dsp_event_combiner_and_int_mux_top dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .event_number(event_number),
    .dsp_interrupt(dsp_interrupt),
    .strobe(strobe),
    .flag_before(flag_before),
    .previous_event(previous_event),
    .combined_word(combined_word),
    .first_pending(first_pending),
    .found(found),
    .combined_lines(combined_lines),
    .error(error)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Applies one access to the shadow state and returns the reply it owes.
  function automatic access_reply_t ctl_access(logic [ACTION_W-1:0] act,
                                               logic [EVENT_W-1:0] ev,
                                               logic [LINE_W-1:0] line);
    access_reply_t r;
    logic [1:0] grp;
    logic [4:0] pos;
    logic [WORD_W-1:0] live;
    int k;
    r = '0;
    grp = ev[6:5];
    pos = ev[4:0];
    case (act)
      ACT_RAISE, ACT_READ_FLAG, ACT_SET, ACT_CLEAR: begin
        r.flag_before = flag_bank[grp][pos];
        if (act == ACT_RAISE || act == ACT_SET) flag_bank[grp][pos] = 1'b1;
        else if (act == ACT_CLEAR) flag_bank[grp][pos] = 1'b0;
      end
      ACT_MASK, ACT_UNMASK: begin
        // events 0..3 can never be masked
        if (ev < LOW_EVENTS) r.error = 1'b1;
        else mask_bank[grp][pos] = (act == ACT_MASK);
      end
      ACT_MAP, ACT_READ_MAP: begin
        if (line < FIRST_LINE) begin
          r.error = 1'b1;
        end else begin
          k = line - FIRST_LINE;
          r.previous_event = irq_map[k];
          if (act == ACT_MAP) irq_map[k] = ev;
        end
      end
      ACT_COMBINED: begin
        if (ev >= GROUPS) begin
          r.error = 1'b1;
        end else begin
          live = flag_bank[ev[1:0]] & ~mask_bank[ev[1:0]];
          r.combined_word = live;
          r.found = |live;
          // walk down so the lowest set bit wins; offset is 32 * group
          for (int b = WORD_W - 1; b >= 0; b--)
            if (live[b]) r.first_pending = {ev[1:0], 5'(b)};
        end
      end
      default: r.error = 1'b1;
    endcase
    for (int g = 0; g < GROUPS; g++)
      r.combined_lines[g] = |(flag_bank[g] & ~mask_bank[g]);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                 logic [WORD_W-1:0] want);
    mismatches++;
    $display("%0t reply %0d: %s got %0h want %0h", $realtime, replies_seen, what,
             got, want);
  endtask

  // Drives one command word and waits for the accepting edge.
  task automatic send_word(logic [ACTION_W-1:0] act, logic [EVENT_W-1:0] ev,
                           logic [LINE_W-1:0] line);
    while (idle_on && $urandom_range(0, 99) < 33) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    action <= act;
    event_number <= ev;
    dsp_interrupt <= line;
    do @(posedge clk); while (busy);
    access_replies.push_back(ctl_access(act, ev, line));
  endtask

  // Mostly a small set of hot events per group so flags and masks collide.
  function automatic logic [EVENT_W-1:0] pick_event();
    int r;
    r = $urandom_range(0, 7);
    if ($urandom_range(0, 99) < 60)
      return {2'($urandom_range(0, GROUPS - 1)), 5'(r < 4 ? r : 24 + r)};
    return EVENT_W'($urandom_range(0, 127));
  endfunction

  task automatic test_flag_access();
    send_word(ACT_RAISE, 7'd0, 4'd0);
    send_word(ACT_RAISE, 7'd0, 4'd0);
    send_word(ACT_READ_FLAG, 7'd0, 4'd0);
    send_word(ACT_SET, 7'd127, 4'd15);
    send_word(ACT_CLEAR, 7'd127, 4'd15);
    send_word(ACT_CLEAR, 7'd127, 4'd15);
  endtask

  task automatic test_masking();
    send_word(ACT_MASK, 7'd0, 4'd0);    // low event, rejected
    send_word(ACT_UNMASK, 7'd3, 4'd0);  // low event, rejected
    send_word(ACT_MASK, 7'd4, 4'd0);
    send_word(ACT_MASK, 7'd127, 4'd0);
    send_word(ACT_UNMASK, 7'd127, 4'd0);
  endtask

  task automatic test_interrupt_map();
    send_word(ACT_MAP, 7'd9, 4'd3);     // bad line
    send_word(ACT_MAP, 7'd127, 4'd4);
    send_word(ACT_READ_MAP, 7'd0, 4'd4);
    send_word(ACT_MAP, 7'd85, 4'd15);
    send_word(ACT_READ_MAP, 7'd0, 4'd2); // bad line
  endtask

  task automatic test_combined_read();
    send_word(ACT_COMBINED, 7'd0, 4'd0);
    send_word(ACT_COMBINED, 7'd1, 4'd0);   // nothing pending there
    send_word(ACT_COMBINED, 7'd3, 4'd0);
    send_word(ACT_COMBINED, 7'd4, 4'd0);   // bad group
    send_word(ACT_COMBINED, 7'd127, 4'd15);
  endtask

  task automatic test_unused_actions();
    send_word(ACT_UNUSED_FIRST, 7'd5, 4'd5);
    send_word(ACT_UNUSED_LAST, 7'd127, 4'd15);
  endtask

  task automatic test_random_traffic(int count);
    logic [ACTION_W-1:0] act;
    logic [EVENT_W-1:0] ev;
    logic [LINE_W-1:0] line;
    int roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      ev = pick_event();
      line = ($urandom_range(0, 99) < 85) ? LINE_W'($urandom_range(FIRST_LINE, LAST_LINE))
                                         : LINE_W'($urandom_range(0, FIRST_LINE - 1));
      if (roll < 14) act = ACT_RAISE;
      else if (roll < 22) act = ACT_SET;
      else if (roll < 42) act = ACT_CLEAR;
      else if (roll < 50) act = ACT_READ_FLAG;
      else if (roll < 58) act = ACT_MASK;
      else if (roll < 66) act = ACT_UNMASK;
      else if (roll < 74) act = ACT_MAP;
      else if (roll < 80) act = ACT_READ_MAP;
      else if (roll < 95) begin
        act = ACT_COMBINED;
        // now and then a group that does not exist
        ev = (roll < 93) ? EVENT_W'($urandom_range(0, GROUPS - 1))
                         : EVENT_W'($urandom_range(0, 127));
      end else begin
        act = ACTION_W'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
      end
      send_word(act, ev, line);
    end
  endtask

  // Every strobe must match the oldest owed reply, field by field.
  always @(posedge clk) begin
    if (!rst && strobe) begin
      replies_seen++;
      if (access_replies.size() == 0) begin
        report_mismatch("reply with no access owed", WORD_W'(strobe), '0);
      end else begin
        reply_head = access_replies.pop_front();
        if (flag_before !== reply_head.flag_before)
          report_mismatch("flag_before", WORD_W'(flag_before),
                          WORD_W'(reply_head.flag_before));
        if (previous_event !== reply_head.previous_event)
          report_mismatch("previous_event", WORD_W'(previous_event),
                          WORD_W'(reply_head.previous_event));
        if (combined_word !== reply_head.combined_word)
          report_mismatch("combined_word", combined_word, reply_head.combined_word);
        if (first_pending !== reply_head.first_pending)
          report_mismatch("first_pending", WORD_W'(first_pending),
                          WORD_W'(reply_head.first_pending));
        if (found !== reply_head.found)
          report_mismatch("found", WORD_W'(found), WORD_W'(reply_head.found));
        if (combined_lines !== reply_head.combined_lines)
          report_mismatch("combined_lines", WORD_W'(combined_lines),
                          WORD_W'(reply_head.combined_lines));
        if (error !== reply_head.error)
          report_mismatch("error", WORD_W'(error), WORD_W'(reply_head.error));
      end
    end
  end

  initial begin
    for (int g = 0; g < GROUPS; g++) begin
      flag_bank[g] = '0;
      mask_bank[g] = '0;
    end
    for (int k = 0; k < MAP_LINES; k++) irq_map[k] = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    test_flag_access();
    test_masking();
    test_interrupt_map();
    test_combined_read();
    test_unused_actions();
    test_random_traffic(500);
    // back-to-back stretch with start held high
    idle_on = 1'b0;
    test_random_traffic(300);
    idle_on = 1'b1;
    test_random_traffic(450);

    @(negedge clk);
    start <= 1'b0;
    while (access_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // The timeout allows well over ten times the length of the run.
  initial begin
    #400_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/dsp_ec_pkg.sv
src/dsp_ec_prienc.sv
src/dsp_ec_map.sv
src/dsp_ec_flags.sv
src/dsp_event_combiner_and_int_mux_top.sv
tb/tb.sv
